FILE: hdl/pfvs_pkg.sv
// ----------------------------------------------------------------------------
// pfvs_pkg
// shared types, constants and the arctangent table for the polar force
// vector sum pipeline
// ----------------------------------------------------------------------------
package pfvs_pkg;

    // default number of micro-rotations in each cordic pass
    localparam int CORDIC_STAGES_DEF = 24;

    // component and angle widths inside the cordic passes
    localparam int CW = 46;
    localparam int ZW = 34;

    localparam logic [16:0] FULL_BEARING = 17'd92160;
    localparam logic [16:0] BRG_90       = 17'd23040;
    localparam logic [16:0] BRG_180      = 17'd46080;
    localparam logic [16:0] BRG_270      = 17'd69120;
    localparam logic [31:0] INV_K        = 32'd2608131496;
    localparam logic [32:0] MAG_MAX      = 33'd8589934590;

    // reciprocals of 45 used for the bearing to binary angle conversion
    localparam logic [17:0] RECIP45_B = 18'd186414;
    localparam logic [27:0] RECIP45_R = 28'd190887436;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [ZW-1:0] rot_angle_t;

    // special-case result carried alongside the vectoring pass
    typedef struct packed {
        logic        spec;
        logic [32:0] mag;
        logic [16:0] brg;
    } pfvs_side_t;

    // round(atan(2^-i) * 2^32 / 360), zero beyond index 30
    function automatic logic [31:0] atan_entry(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            24: val = 32'd41;
            25: val = 32'd20;
            26: val = 32'd10;
            27: val = 32'd5;
            28: val = 32'd3;
            29: val = 32'd1;
            30: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/pfvs_prep.sv
// ----------------------------------------------------------------------------
// pfvs_prep
// turns one magnitude and bearing into the start vector and residual angle
// of the rotation pass, over five register stages
// ----------------------------------------------------------------------------
module pfvs_prep
    import pfvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] mag,
    input  logic [16:0] brg,
    output logic        out_valid,
    output comp_t       x_start,
    output rot_angle_t  z_start
);

    logic [16:0] brg_wrap;
    logic        a_valid_reg;
    logic [31:0] a_mag_reg;
    logic [16:0] a_brg_reg;
    logic [63:0] prod_m;
    logic [64:0] x_round;
    logic [34:0] prod_b;
    logic        b_valid_reg;
    logic [39:0] b_x_reg;
    logic [10:0] b_q_reg;
    logic [16:0] b_brg_reg;
    logic [16:0] rem_full;
    logic        c_valid_reg;
    logic [39:0] c_x_reg;
    logic [10:0] c_q_reg;
    logic [5:0]  c_r_reg;
    logic [26:0] num_r;
    logic [54:0] prod_r;
    logic        d_valid_reg;
    logic [39:0] d_x_reg;
    logic [31:0] d_a_reg;
    comp_t       x_pos;
    comp_t       x_next;
    rot_angle_t  z_next;
    logic        e_valid_reg;
    comp_t       e_x_reg;
    rot_angle_t  e_z_reg;

    // bring an out of range bearing back into one turn
    always_comb
    begin
        brg_wrap = (brg >= FULL_BEARING) ? brg - FULL_BEARING : brg;
    end

    // valid bits through the five stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // prescale by the inverse gain and divide the bearing by 45
    always_comb
    begin
        prod_m  = {32'd0, a_mag_reg} * {32'd0, INV_K};
        x_round = {1'b0, prod_m} + 65'd8388608;
        prod_b  = {18'd0, a_brg_reg} * {17'd0, RECIP45_B};
    end

    // remainder of the bearing after the quotient by 45
    always_comb
    begin
        rem_full = b_brg_reg - 17'({6'd0, b_q_reg} * 17'd45);
    end

    // remainder part of the binary angle, rounded
    always_comb
    begin
        num_r  = {c_r_reg, 21'd0} + 27'd22;
        prod_r = {28'd0, num_r} * {27'd0, RECIP45_R};
    end

    // quadrant fold of the start vector and angle
    always_comb
    begin
        x_pos = {{(CW-40){1'b0}}, d_x_reg};
        case (d_a_reg[31:30])
            2'd0:
            begin
                x_next = x_pos;
                z_next = {2'b00, d_a_reg};
            end
            2'd3:
            begin
                x_next = x_pos;
                z_next = {2'b11, d_a_reg};
            end
            default:
            begin
                x_next = -x_pos;
                z_next = {2'b00, d_a_reg} - 34'sd2147483648;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg <= mag;
            a_brg_reg <= brg_wrap;
            b_x_reg   <= x_round[63:24];
            b_q_reg   <= prod_b[33:23];
            b_brg_reg <= a_brg_reg;
            c_x_reg   <= b_x_reg;
            c_q_reg   <= b_q_reg;
            c_r_reg   <= rem_full[5:0];
            d_x_reg   <= c_x_reg;
            d_a_reg   <= {c_q_reg, prod_r[53:33]};
            e_x_reg   <= x_next;
            e_z_reg   <= z_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign x_start   = e_x_reg;
    assign z_start   = e_z_reg;

endmodule

FILE: hdl/pfvs_rotate.sv
// ----------------------------------------------------------------------------
// pfvs_rotate
// unrolled cordic rotation pass, one registered micro-rotation per stage
// ----------------------------------------------------------------------------
module pfvs_rotate
    import pfvs_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  comp_t      x_in,
    input  rot_angle_t z_in,
    output logic       out_valid,
    output comp_t      north,
    output comp_t      east
);

    logic       v_reg [1:STAGES];
    comp_t      x_reg [1:STAGES];
    comp_t      y_reg [1:STAGES];
    rot_angle_t z_reg [1:STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic       vi;
        comp_t      xi;
        comp_t      yi;
        rot_angle_t zi;
        comp_t      dx;
        comp_t      dy;
        rot_angle_t tab;
        comp_t      x_next;
        comp_t      y_next;
        rot_angle_t z_next;

        if (i == 0)
        begin : g_first
            assign vi = in_valid;
            assign xi = x_in;
            assign yi = '0;
            assign zi = z_in;
        end
        else
        begin : g_next
            assign vi = v_reg[i];
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
        end

        // micro-rotation toward zero residual angle
        always_comb
        begin
            dx  = yi >>> i;
            dy  = xi >>> i;
            tab = {{(ZW-32){1'b0}}, atan_entry(i)};
            if (zi >= 0)
            begin
                x_next = xi - dx;
                y_next = yi + dy;
                z_next = zi - tab;
            end
            else
            begin
                x_next = xi + dx;
                y_next = yi - dy;
                z_next = zi + tab;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign north     = x_reg[STAGES];
    assign east      = y_reg[STAGES];

endmodule

FILE: hdl/pfvs_vector.sv
// ----------------------------------------------------------------------------
// pfvs_vector
// sums the components, handles the axis cases, runs the cordic vectoring
// pass and scales the result into magnitude and bearing
// ----------------------------------------------------------------------------
module pfvs_vector
    import pfvs_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  comp_t       n1,
    input  comp_t       e1,
    input  comp_t       n2,
    input  comp_t       e2,
    output logic        out_valid,
    output logic [32:0] sum_magnitude,
    output logic [16:0] sum_bearing
);

    logic        s_valid_reg;
    comp_t       s_n_reg;
    comp_t       s_e_reg;
    logic        n_zero;
    logic        e_zero;
    comp_t       axis_val;
    comp_t       axis_abs;
    logic [CW:0] axis_rnd;
    logic [CW-8:0] axis_q;
    pfvs_side_t  side_next;
    comp_t       x0_next;
    comp_t       y0_next;
    logic [31:0] z0_next;
    logic        k_valid_reg;
    comp_t       k_x_reg;
    comp_t       k_y_reg;
    logic [31:0] k_z_reg;
    pfvs_side_t  k_side_reg;

    logic        v_reg    [1:STAGES];
    comp_t       x_reg    [1:STAGES];
    comp_t       y_reg    [1:STAGES];
    logic [31:0] z_reg    [1:STAGES];
    pfvs_side_t  side_reg [1:STAGES];

    logic [CW-17:0] ux_hi;
    logic [61:0]    prod_hi;
    logic [47:0]    prod_lo;
    logic        f_valid_reg;
    logic [61:0] f_hi_reg;
    logic [31:0] f_lo_reg;
    logic [31:0] f_z_reg;
    pfvs_side_t  f_side_reg;
    logic [62:0] p_rnd;
    logic [38:0] mag_raw;
    logic [32:0] mag_next;
    logic [37:0] brg_prod;
    logic [16:0] brg_raw;
    logic [16:0] brg_next;
    logic        out_valid_reg;
    logic [32:0] out_mag_reg;
    logic [16:0] out_brg_reg;

    // axis cases and start of the vectoring pass
    always_comb
    begin
        n_zero   = (s_n_reg == '0);
        e_zero   = (s_e_reg == '0);
        axis_val = n_zero ? s_e_reg : s_n_reg;
        axis_abs = (axis_val < 0) ? -axis_val : axis_val;
        axis_rnd = {1'b0, axis_abs} + (CW+1)'(128);
        axis_q   = axis_rnd[CW:8];
        side_next.spec = n_zero | e_zero;
        side_next.mag  = (axis_q > {{(CW-40){1'b0}}, MAG_MAX}) ? MAG_MAX : axis_q[32:0];
        if (n_zero && e_zero)
            side_next.brg = 17'd0;
        else if (n_zero)
            side_next.brg = (s_e_reg > 0) ? BRG_90 : BRG_270;
        else
            side_next.brg = (s_n_reg > 0) ? 17'd0 : BRG_180;
        if (s_n_reg < 0)
        begin
            x0_next = -s_n_reg;
            y0_next = -s_e_reg;
            z0_next = 32'h8000_0000;
        end
        else
        begin
            x0_next = s_n_reg;
            y0_next = s_e_reg;
            z0_next = 32'd0;
        end
    end

    // valid bits for the sum, setup, scale and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            k_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg   <= in_valid;
            k_valid_reg   <= s_valid_reg;
            f_valid_reg   <= v_reg[STAGES];
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_n_reg    <= n1 + n2;
            s_e_reg    <= e1 + e2;
            k_x_reg    <= x0_next;
            k_y_reg    <= y0_next;
            k_z_reg    <= z0_next;
            k_side_reg <= side_next;
        end
    end

    // unrolled vectoring stages
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic        vi;
        comp_t       xi;
        comp_t       yi;
        logic [31:0] zi;
        pfvs_side_t  si;
        comp_t       dx;
        comp_t       dy;
        comp_t       x_next;
        comp_t       y_next;
        logic [31:0] z_next;

        if (i == 0)
        begin : g_first
            assign vi = k_valid_reg;
            assign xi = k_x_reg;
            assign yi = k_y_reg;
            assign zi = k_z_reg;
            assign si = k_side_reg;
        end
        else
        begin : g_next
            assign vi = v_reg[i];
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign si = side_reg[i];
        end

        // rotate toward the north axis, angle wraps modulo one turn
        always_comb
        begin
            dx = yi >>> i;
            dy = xi >>> i;
            if (yi > 0)
            begin
                x_next = xi + dx;
                y_next = yi - dy;
                z_next = zi + atan_entry(i);
            end
            else
            begin
                x_next = xi - dx;
                y_next = yi + dy;
                z_next = zi - atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                side_reg[i+1] <= si;
            end
        end
    end

    // gain correction products, split at bit 16
    always_comb
    begin
        ux_hi   = x_reg[STAGES][CW-1:16];
        prod_hi = 62'({{(62-(CW-16)){1'b0}}, ux_hi} * {30'd0, INV_K});
        prod_lo = {32'd0, x_reg[STAGES][15:0]} * {16'd0, INV_K};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_hi_reg   <= prod_hi;
            f_lo_reg   <= prod_lo[47:16];
            f_z_reg    <= z_reg[STAGES];
            f_side_reg <= side_reg[STAGES];
        end
    end

    // rounding, saturation and binary angle to bearing
    always_comb
    begin
        p_rnd    = {1'b0, f_hi_reg} + {31'd0, f_lo_reg} + 63'd8388608;
        mag_raw  = p_rnd[62:24];
        mag_next = (mag_raw > {6'd0, MAG_MAX}) ? MAG_MAX : mag_raw[32:0];
        brg_prod = {6'd0, f_z_reg} * 38'd45 + 38'd1048576;
        brg_raw  = brg_prod[37:21];
        brg_next = (brg_raw >= FULL_BEARING) ? 17'd0 : brg_raw;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mag_reg <= f_side_reg.spec ? f_side_reg.mag : mag_next;
            out_brg_reg <= f_side_reg.spec ? f_side_reg.brg : brg_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sum_magnitude = out_mag_reg;
    assign sum_bearing   = out_brg_reg;

endmodule

FILE: hdl/polar_force_vector_sum.sv
// ----------------------------------------------------------------------------
// polar_force_vector_sum
// adds two forces given as magnitude and bearing and returns the resultant
// as magnitude and bearing
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  s_axis    in   first_magnitude, first_bearing, second_magnitude,
//                 second_bearing
//  m_axis    out  sum_magnitude, sum_bearing
//
//  one force pair enters per clock unless a result waits; each result
//  passes through the prep stages and the two unrolled cordic passes
//  the whole pipeline advances together: it holds while a result waits
//  reset clears only the valid bits; no state is kept between transfers
// ----------------------------------------------------------------------------
module polar_force_vector_sum
    import pfvs_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_magnitude[31:0], first_bearing[48:32], second_magnitude[80:49],
    // second_bearing[97:81], zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sum_magnitude[32:0], sum_bearing[49:33], zero fill
    output logic [55:0]  m_tdata
);

    logic        en;
    logic        p1_valid;
    logic        p2_valid;
    comp_t       p1_x;
    comp_t       p2_x;
    rot_angle_t  p1_z;
    rot_angle_t  p2_z;
    logic        r1_valid;
    logic        r2_valid;
    comp_t       n1;
    comp_t       e1;
    comp_t       n2;
    comp_t       e2;
    logic [32:0] sum_magnitude;
    logic [16:0] sum_bearing;

    // pipeline advances unless a result is stuck at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    pfvs_prep u_prep1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .mag       (s_tdata[31:0]),
        .brg       (s_tdata[48:32]),
        .out_valid (p1_valid),
        .x_start   (p1_x),
        .z_start   (p1_z)
    );

    pfvs_prep u_prep2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .mag       (s_tdata[80:49]),
        .brg       (s_tdata[97:81]),
        .out_valid (p2_valid),
        .x_start   (p2_x),
        .z_start   (p2_z)
    );

    pfvs_rotate #(.STAGES(CORDIC_STAGES)) u_rot1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_valid),
        .x_in      (p1_x),
        .z_in      (p1_z),
        .out_valid (r1_valid),
        .north     (n1),
        .east      (e1)
    );

    pfvs_rotate #(.STAGES(CORDIC_STAGES)) u_rot2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid),
        .x_in      (p2_x),
        .z_in      (p2_z),
        .out_valid (r2_valid),
        .north     (n2),
        .east      (e2)
    );

    pfvs_vector #(.STAGES(CORDIC_STAGES)) u_vector (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (r1_valid & r2_valid),
        .n1            (n1),
        .e1            (e1),
        .n2            (n2),
        .e2            (e2),
        .out_valid     (m_tvalid),
        .sum_magnitude (sum_magnitude),
        .sum_bearing   (sum_bearing)
    );

    assign m_tdata = {6'd0, sum_bearing, sum_magnitude};

    // both force lanes stay in step
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid == p2_valid && r1_valid == r2_valid)
        else $error("force lanes out of step");

    // result bearing stays within one turn
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[49:33] < FULL_BEARING)
        else $error("bearing out of range");

    // result magnitude saturates at the top of its range
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:0] <= MAG_MAX)
        else $error("magnitude beyond saturation");

endmodule
